// ----- rtl/core/lsrc_pkg.sv -----
// Shared types, constants and datapath functions for the line segment clipper.
// No dependencies; every other file of the clipper imports this package.
`default_nettype none

package lsrc_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 4;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int CW              = 16;                 // coordinate width
    localparam int DW              = CW + 1;             // difference width
    localparam int RW              = DW + 1;             // divider remainder width
    localparam int QW              = PARAM_FRAC_BITS + 1; // quotient magnitude bits
    localparam int TW              = PARAM_FRAC_BITS + 2; // signed t width
    localparam int PIX_W           = 12;
    localparam int PW              = TW + DW;            // product width
    localparam int NUM_W           = PW + 1;             // interpolation sum width
    localparam int SHIFT           = PARAM_FRAC_BITS + COORD_FRAC_BITS;
    localparam int LANES           = 4;
    localparam int CFG_IDX_W       = 3;

    // Pipeline depth: two setup stages, divider, finalize, two narrow, three interp
    localparam int PIPE_LATENCY    = 2 + QW + 6;

    // Boundary lanes
    localparam int B_LEFT   = 0;
    localparam int B_RIGHT  = 1;
    localparam int B_TOP    = 2;
    localparam int B_BOTTOM = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(3);

    localparam logic signed [CW-1:0] EDGE_LOW_RESET  = '0;
    localparam logic signed [CW-1:0] EDGE_HIGH_RESET = {1'b0, {(CW-1){1'b1}}};

    // Line parameter constants
    localparam logic signed [TW-1:0] T_ZERO  = '0;
    localparam logic signed [TW-1:0] T_ONE   = TW'(1) <<< PARAM_FRAC_BITS;
    localparam logic signed [TW-1:0] T_MAX   = T_ONE + TW'(1);
    localparam logic signed [TW-1:0] T_NEG   = '1;
    localparam logic [TW-1:0]        T_MAX_U = TW'(T_MAX);

    localparam logic signed [NUM_W-1:0] ROUND_BIAS = NUM_W'((64'sd1 <<< SHIFT) - 64'sd1);

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic                    visible;
        logic signed [PIX_W-1:0] clipped_start_x;
        logic signed [PIX_W-1:0] clipped_start_y;
        logic signed [PIX_W-1:0] clipped_end_x;
        logic signed [PIX_W-1:0] clipped_end_y;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] bottom;
    } clip_t;

    // Segment data that rides alongside the divider
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } side_t;

    // One boundary lane inside the divider
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] dvs;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
        logic          pzero;
        logic          qneg;
        logic          pneg;
    } div_lane_t;

    typedef struct packed {
        logic signed [TW-1:0] t;
        logic                 pzero;
        logic                 qneg;
        logic                 pneg;
    } tval_t;

    typedef struct packed {
        logic                 vis;
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
    } nstate_t;

    // One restoring division step; the first step also flags quotient overflow
    function automatic div_lane_t div_step(input div_lane_t a, input logic first);
        div_lane_t     r;
        logic [RW-1:0] trial;
        logic [RW-1:0] dext;
        r     = a;
        dext  = {1'b0, a.dvs};
        trial = first ? a.rem : {a.rem[RW-2:0], 1'b0};
        if (first) begin
            r.ovf = (a.rem >= {a.dvs, 1'b0});
        end
        if (trial >= dext) begin
            r.rem = trial - dext;
            r.quo = {a.quo[QW-2:0], 1'b1};
        end else begin
            r.rem = trial;
            r.quo = {a.quo[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    // Signed, saturated t from quotient magnitude and sign
    function automatic tval_t finalize(input div_lane_t a);
        tval_t         r;
        logic [TW-1:0] qext;
        qext    = TW'(a.quo);
        r.pzero = a.pzero;
        r.qneg  = a.qneg;
        r.pneg  = a.pneg;
        if (a.neg) begin
            r.t = (a.quo == '0 && !a.ovf) ? T_ZERO : T_NEG;
        end else if (a.ovf || qext > T_MAX_U) begin
            r.t = T_MAX;
        end else begin
            r.t = $signed(qext);
        end
        return r;
    endfunction

    // Narrow entry/exit parameters against one boundary
    function automatic nstate_t narrow_step(input nstate_t s, input tval_t v);
        nstate_t r;
        r = s;
        if (s.vis) begin
            if (v.pzero) begin
                if (v.qneg) begin
                    r.vis = 1'b0;
                end
            end else if (v.pneg) begin
                if (v.t > s.t1) begin
                    r.vis = 1'b0;
                end else if (v.t > s.t0) begin
                    r.t0 = v.t;
                end
            end else begin
                if (v.t < s.t0) begin
                    r.vis = 1'b0;
                end else if (v.t < s.t1) begin
                    r.t1 = v.t;
                end
            end
        end
        return r;
    endfunction

    // Whole pixel, truncated toward zero
    function automatic logic signed [PIX_W-1:0] pixel(input logic signed [NUM_W-1:0] num);
        logic signed [NUM_W-1:0] adj;
        adj = num + (num[NUM_W-1] ? ROUND_BIAS : '0);
        return PIX_W'(adj >>> SHIFT);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lsrc_setup.sv -----
// Front two pipeline stages: edge distances, deltas, then divider operands.
// Depends on lsrc_pkg.
`default_nettype none

module lsrc_setup (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire lsrc_pkg::in_t                       item,
    input  wire lsrc_pkg::clip_t                     clip,
    output logic                                     out_valid,
    output lsrc_pkg::div_lane_t [lsrc_pkg::LANES-1:0] lanes,
    output lsrc_pkg::side_t                          side
);
    import lsrc_pkg::*;

    logic                             a_valid_reg;
    side_t                            a_side_reg;
    logic signed [LANES-1:0][DW-1:0]  a_q_reg;
    side_t                            a_side_next;
    logic signed [LANES-1:0][DW-1:0]  a_q_next;

    logic                             b_valid_reg;
    side_t                            b_side_reg;
    div_lane_t [LANES-1:0]            b_lane_reg;
    div_lane_t [LANES-1:0]            b_lane_next;

    logic [DW-1:0]                    abs_dx;
    logic [DW-1:0]                    abs_dy;
    logic                             dx_pos;
    logic                             dx_neg;
    logic                             dy_pos;
    logic                             dy_neg;
    logic [LANES-1:0]                 lane_pneg;
    logic [LANES-1:0]                 lane_pzero;
    logic [LANES-1:0][DW-1:0]         lane_dvs;

    // Stage A: deltas and signed distances to each edge
    always_comb
    begin
        a_side_next.x0 = item.start_x;
        a_side_next.y0 = item.start_y;
        a_side_next.dx = DW'(item.end_x) - DW'(item.start_x);
        a_side_next.dy = DW'(item.end_y) - DW'(item.start_y);
        a_q_next[B_LEFT]   = DW'(item.start_x) - DW'(clip.left);
        a_q_next[B_RIGHT]  = DW'(clip.right) - DW'(item.start_x);
        a_q_next[B_TOP]    = DW'(item.start_y) - DW'(clip.top);
        a_q_next[B_BOTTOM] = DW'(clip.bottom) - DW'(item.start_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        a_q_reg    <= a_q_next;
    end

    // Stage B: magnitudes and signs of p and q for each boundary
    always_comb
    begin
        abs_dx = a_side_reg.dx[DW-1] ? DW'(-a_side_reg.dx) : DW'(a_side_reg.dx);
        abs_dy = a_side_reg.dy[DW-1] ? DW'(-a_side_reg.dy) : DW'(a_side_reg.dy);
        dx_neg = a_side_reg.dx[DW-1];
        dy_neg = a_side_reg.dy[DW-1];
        dx_pos = !dx_neg && (a_side_reg.dx != '0);
        dy_pos = !dy_neg && (a_side_reg.dy != '0);

        // p = -dx, dx, -dy, dy
        lane_pneg[B_LEFT]    = dx_pos;
        lane_pneg[B_RIGHT]   = dx_neg;
        lane_pneg[B_TOP]     = dy_pos;
        lane_pneg[B_BOTTOM]  = dy_neg;
        lane_pzero[B_LEFT]   = (a_side_reg.dx == '0);
        lane_pzero[B_RIGHT]  = (a_side_reg.dx == '0);
        lane_pzero[B_TOP]    = (a_side_reg.dy == '0);
        lane_pzero[B_BOTTOM] = (a_side_reg.dy == '0);
        lane_dvs[B_LEFT]     = abs_dx;
        lane_dvs[B_RIGHT]    = abs_dx;
        lane_dvs[B_TOP]      = abs_dy;
        lane_dvs[B_BOTTOM]   = abs_dy;

        for (int l = 0; l < LANES; l++) begin
            b_lane_next[l].qneg  = a_q_reg[l][DW-1];
            b_lane_next[l].rem   = a_q_reg[l][DW-1] ? RW'(DW'(-a_q_reg[l])) :
                                                      RW'(DW'(a_q_reg[l]));
            b_lane_next[l].dvs   = lane_dvs[l];
            b_lane_next[l].quo   = '0;
            b_lane_next[l].pneg  = lane_pneg[l];
            b_lane_next[l].pzero = lane_pzero[l];
            b_lane_next[l].neg   = a_q_reg[l][DW-1] ^ lane_pneg[l];
            b_lane_next[l].ovf   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= a_side_reg;
        b_lane_reg <= b_lane_next;
    end

    assign out_valid = b_valid_reg;
    assign lanes     = b_lane_reg;
    assign side      = b_side_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lsrc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, four boundary lanes.
// Depends on lsrc_pkg.
`default_nettype none

module lsrc_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire lsrc_pkg::div_lane_t [lsrc_pkg::LANES-1:0] in_lanes,
    input  wire lsrc_pkg::side_t                     in_side,
    output logic                                     out_valid,
    output lsrc_pkg::div_lane_t [lsrc_pkg::LANES-1:0] out_lanes,
    output lsrc_pkg::side_t                          out_side
);
    import lsrc_pkg::*;

    logic                  valid_reg [QW];
    div_lane_t [LANES-1:0] lane_reg [QW];
    div_lane_t [LANES-1:0] lane_next [QW];
    side_t                 side_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        div_lane_t [LANES-1:0] src;
        side_t                 src_side;
        logic                  src_valid;

        if (s == 0) begin : g_first
            assign src       = in_lanes;
            assign src_side  = in_side;
            assign src_valid = in_valid;
        end else begin : g_rest
            assign src       = lane_reg[s-1];
            assign src_side  = side_reg[s-1];
            assign src_valid = valid_reg[s-1];
        end

        // One quotient bit for every lane
        always_comb
        begin
            for (int l = 0; l < LANES; l++) begin
                lane_next[s][l] = div_step(src[l], 1'(s == 0));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[s] <= 1'b0;
            end else begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            lane_reg[s] <= lane_next[s];
            side_reg[s] <= src_side;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_lanes = lane_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/lsrc_narrow.sv -----
// Saturates the four t values, then narrows entry/exit over two stages.
// Depends on lsrc_pkg.
`default_nettype none

module lsrc_narrow (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire lsrc_pkg::div_lane_t [lsrc_pkg::LANES-1:0] in_lanes,
    input  wire lsrc_pkg::side_t                     in_side,
    output logic                                     out_valid,
    output lsrc_pkg::nstate_t                        out_state,
    output lsrc_pkg::side_t                          out_side
);
    import lsrc_pkg::*;

    logic              f_valid_reg;
    tval_t [LANES-1:0] f_tv_reg;
    tval_t [LANES-1:0] f_tv_next;
    side_t             f_side_reg;

    logic              n1_valid_reg;
    nstate_t           n1_state_reg;
    nstate_t           n1_state_next;
    tval_t [1:0]       n1_tv_reg;
    side_t             n1_side_reg;

    logic              n2_valid_reg;
    nstate_t           n2_state_reg;
    nstate_t           n2_state_next;
    side_t             n2_side_reg;

    nstate_t           init_state;

    // Stage F: signed, saturated t per boundary
    always_comb
    begin
        for (int l = 0; l < LANES; l++) begin
            f_tv_next[l] = finalize(in_lanes[l]);
        end
    end

    // Stages N1 and N2: left/right, then top/bottom, in that order
    always_comb
    begin
        init_state.vis = 1'b1;
        init_state.t0  = T_ZERO;
        init_state.t1  = T_ONE;
        n1_state_next  = narrow_step(narrow_step(init_state, f_tv_reg[B_LEFT]),
                                     f_tv_reg[B_RIGHT]);
        n2_state_next  = narrow_step(narrow_step(n1_state_reg, n1_tv_reg[0]),
                                     n1_tv_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f_valid_reg  <= 1'b0;
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
        end else begin
            f_valid_reg  <= in_valid;
            n1_valid_reg <= f_valid_reg;
            n2_valid_reg <= n1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_tv_reg     <= f_tv_next;
        f_side_reg   <= in_side;
        n1_state_reg <= n1_state_next;
        n1_tv_reg[0] <= f_tv_reg[B_TOP];
        n1_tv_reg[1] <= f_tv_reg[B_BOTTOM];
        n1_side_reg  <= f_side_reg;
        n2_state_reg <= n2_state_next;
        n2_side_reg  <= n1_side_reg;
    end

    assign out_valid = n2_valid_reg;
    assign out_state = n2_state_reg;
    assign out_side  = n2_side_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lsrc_interp.sv -----
// Endpoint interpolation: multiply, sum, truncate to pixels into the result register.
// Depends on lsrc_pkg.
`default_nettype none

module lsrc_interp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire lsrc_pkg::nstate_t in_state,
    input  wire lsrc_pkg::side_t   in_side,
    output logic                   done,
    output lsrc_pkg::out_t         result
);
    import lsrc_pkg::*;

    logic                            m_valid_reg;
    logic                            m_vis_reg;
    logic signed [CW-1:0]            m_x0_reg;
    logic signed [CW-1:0]            m_y0_reg;
    logic signed [LANES-1:0][PW-1:0] m_prod_reg;
    logic signed [LANES-1:0][PW-1:0] m_prod_next;
    logic signed [TW-1:0]            t0_u;
    logic signed [TW-1:0]            t1_u;

    logic                               s_valid_reg;
    logic                               s_vis_reg;
    logic signed [LANES-1:0][NUM_W-1:0] s_num_reg;
    logic signed [LANES-1:0][NUM_W-1:0] s_num_next;

    logic done_reg;
    out_t result_reg;
    out_t result_next;

    // Stage M: t times delta; t0 and t1 lie in [0, 1.0] here
    always_comb
    begin
        t0_u = $signed({1'b0, in_state.t0[QW-1:0]});
        t1_u = $signed({1'b0, in_state.t1[QW-1:0]});
        m_prod_next[0] = PW'(t0_u * in_side.dx);
        m_prod_next[1] = PW'(t0_u * in_side.dy);
        m_prod_next[2] = PW'(t1_u * in_side.dx);
        m_prod_next[3] = PW'(t1_u * in_side.dy);
    end

    // Stage S: start coordinate scaled to the parameter format plus product
    always_comb
    begin
        s_num_next[0] = (NUM_W'(m_x0_reg) <<< PARAM_FRAC_BITS) +
                        NUM_W'($signed(m_prod_reg[0]));
        s_num_next[1] = (NUM_W'(m_y0_reg) <<< PARAM_FRAC_BITS) +
                        NUM_W'($signed(m_prod_reg[1]));
        s_num_next[2] = (NUM_W'(m_x0_reg) <<< PARAM_FRAC_BITS) +
                        NUM_W'($signed(m_prod_reg[2]));
        s_num_next[3] = (NUM_W'(m_y0_reg) <<< PARAM_FRAC_BITS) +
                        NUM_W'($signed(m_prod_reg[3]));
    end

    // Stage O: truncate toward zero; rejected segments read all zero
    always_comb
    begin
        result_next.visible         = s_vis_reg;
        result_next.clipped_start_x = s_vis_reg ? pixel(s_num_reg[0]) : '0;
        result_next.clipped_start_y = s_vis_reg ? pixel(s_num_reg[1]) : '0;
        result_next.clipped_end_x   = s_vis_reg ? pixel(s_num_reg[2]) : '0;
        result_next.clipped_end_y   = s_vis_reg ? pixel(s_num_reg[3]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            m_valid_reg <= in_valid;
            s_valid_reg <= m_valid_reg;
            done_reg    <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_vis_reg  <= in_state.vis;
        m_x0_reg   <= in_side.x0;
        m_y0_reg   <= in_side.y0;
        m_prod_reg <= m_prod_next;
        s_vis_reg  <= m_vis_reg;
        s_num_reg  <= s_num_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/line_segment_rect_clipper.sv -----
// Liang-Barsky segment clipper against a rectangle held in registers.
// Depends on lsrc_pkg, lsrc_setup, lsrc_div, lsrc_narrow and lsrc_interp.
//
// Usage:
//   Input: raise start with a segment on item; it is taken at any rising edge
//   where start is high and busy is low. busy stays low, so one segment can
//   be taken every cycle.
//   Output: done is high for one cycle with the result on result once the
//   segment has passed 2 setup stages, 17 divider stages (one quotient bit
//   each), then 1 saturate, 2 narrowing and 3 interpolation stages.
//   Throughput is one segment per cycle; results leave in order.
//   The receiver cannot stall: every result is shown for exactly one cycle.
//   Configuration: cfg_we with cfg_index (0 left, 1 top, 2 right, 3 bottom)
//   writes cfg_data at that edge; other indexes are ignored. Write only while
//   no segment is in flight.
//   Reset: clears all pipeline valid bits and sets the rectangle to
//   left = top = 0, right = bottom = 32767.
`default_nettype none

module line_segment_rect_clipper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire lsrc_pkg::in_t                      item,
    output logic                                    done,
    output lsrc_pkg::out_t                          result,
    input  wire logic                               cfg_we,
    input  wire logic [lsrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsrc_pkg::CW-1:0]            cfg_data
);
    import lsrc_pkg::*;

    clip_t                 clip_reg;
    clip_t                 clip_next;
    logic                  accept;

    logic                  su_valid;
    div_lane_t [LANES-1:0] su_lanes;
    side_t                 su_side;
    logic                  dv_valid;
    div_lane_t [LANES-1:0] dv_lanes;
    side_t                 dv_side;
    logic                  nr_valid;
    nstate_t               nr_state;
    side_t                 nr_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clip rectangle registers
    always_comb
    begin
        clip_next = clip_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_LEFT:   clip_next.left   = $signed(cfg_data);
                REG_TOP:    clip_next.top    = $signed(cfg_data);
                REG_RIGHT:  clip_next.right  = $signed(cfg_data);
                REG_BOTTOM: clip_next.bottom = $signed(cfg_data);
                default:    clip_next        = clip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clip_reg.left   <= EDGE_LOW_RESET;
            clip_reg.top    <= EDGE_LOW_RESET;
            clip_reg.right  <= EDGE_HIGH_RESET;
            clip_reg.bottom <= EDGE_HIGH_RESET;
        end else begin
            clip_reg <= clip_next;
        end
    end

    lsrc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .item      (item),
        .clip      (clip_reg),
        .out_valid (su_valid),
        .lanes     (su_lanes),
        .side      (su_side)
    );

    lsrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .in_lanes  (su_lanes),
        .in_side   (su_side),
        .out_valid (dv_valid),
        .out_lanes (dv_lanes),
        .out_side  (dv_side)
    );

    lsrc_narrow u_narrow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_lanes  (dv_lanes),
        .in_side   (dv_side),
        .out_valid (nr_valid),
        .out_state (nr_state),
        .out_side  (nr_side)
    );

    lsrc_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nr_valid),
        .in_state (nr_state),
        .in_side  (nr_side),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lsrc_checker.sv -----
// Port-level assertions for the clipper, bound to the top level.
// Depends on lsrc_pkg and line_segment_rect_clipper.
`default_nettype none

module lsrc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire lsrc_pkg::out_t result
);
    import lsrc_pkg::*;

    // Every result traces back to a transaction a fixed latency earlier
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, PIPE_LATENCY))
        else $error("result without matching transaction");

    // Rejected segments carry zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.visible) |->
            (result.clipped_start_x == '0 && result.clipped_start_y == '0 &&
             result.clipped_end_x == '0 && result.clipped_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    // Pipeline is empty right after reset
    a_reset_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !done)
        else $error("result right after reset");

endmodule

bind line_segment_rect_clipper lsrc_checker u_lsrc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the Liang-Barsky segment clipper.
// Depends on lsrc_pkg and line_segment_rect_clipper; predicts each result and compares.
`timescale 1ns / 100ps

module testbench;
    import lsrc_pkg::*;

    localparam int LAT = 25;
    localparam int WD_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t item = '0;
    logic done;
    out_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    // Shadow rectangle
    longint rect_left, rect_top, rect_right, rect_bottom;

    in_t segments_pending[$];
    out_t clips_expected[$];
    int errors = 0;
    bit quiet_run = 1'b0;
    int gap_left = 0;
    int watchdog = 0;

    line_segment_rect_clipper uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Whole pixel at parameter t, truncated toward zero
    function automatic logic signed [PIX_W-1:0] pixel_on_line(longint c0, longint d, longint t);
        longint num;
        num = c0 * 65536 + t * d;
        return PIX_W'(num / (longint'(1) << 20));
    endfunction

    function automatic out_t clip_segment(in_t s);
        out_t r;
        longint x0, y0, dx, dy, t, t_in, t_out;
        longint p[4];
        longint q[4];
        bit vis;
        x0 = s.start_x; y0 = s.start_y;
        dx = longint'(s.end_x) - x0;
        dy = longint'(s.end_y) - y0;
        t_in = 0; t_out = 65536; vis = 1'b1;
        p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
        q[0] = x0 - rect_left; q[1] = rect_right - x0;
        q[2] = y0 - rect_top; q[3] = rect_bottom - y0;
        for (int i = 0; i < 4; i++) begin
            if (!vis) continue;
            if (p[i] == 0) begin
                if (q[i] < 0) vis = 1'b0;
                continue;
            end
            t = (q[i] * 65536) / p[i];
            if (t < -1) t = -1;
            if (t > 65537) t = 65537;
            if (p[i] < 0) begin
                if (t > t_out) vis = 1'b0;
                else if (t > t_in) t_in = t;
            end else begin
                if (t < t_in) vis = 1'b0;
                else if (t < t_out) t_out = t;
            end
        end
        r = '0;
        if (vis) begin
            r.visible = 1'b1;
            r.clipped_start_x = pixel_on_line(x0, dx, t_in);
            r.clipped_start_y = pixel_on_line(y0, dy, t_in);
            r.clipped_end_x = pixel_on_line(x0, dx, t_out);
            r.clipped_end_y = pixel_on_line(y0, dy, t_out);
        end
        return r;
    endfunction

    // Driver: one transaction per accepted edge, random idle bursts unless quiet_run is set
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy) begin
                clips_expected.push_back(clip_segment(item));
                void'(segments_pending.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (segments_pending.size() > 0
                         && !(start && !busy && !quiet_run && $urandom_range(0, 9) == 0)) begin
                start <= 1'b1;
                item <= segments_pending[0];
            end else begin
                start <= 1'b0;
                if (start && !busy && !quiet_run) gap_left <= $urandom_range(0, 7);
            end
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done) begin
                out_t e;
                if (clips_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, result);
                    errors++;
                end else begin
                    e = clips_expected.pop_front();
                    if (e.visible !== result.visible ||
                        e.clipped_start_x !== result.clipped_start_x ||
                        e.clipped_start_y !== result.clipped_start_y ||
                        e.clipped_end_x !== result.clipped_end_x ||
                        e.clipped_end_y !== result.clipped_end_y) begin
                        $display("%0t: mismatch, expected %h actual %h", $time, e, result);
                        errors++;
                    end
                end
            end
            if (done || (start && !busy) || cfg_we) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (watchdog >= WD_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic set_rect(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEFT: rect_left = longint'($signed(v));
            REG_TOP: rect_top = longint'($signed(v));
            REG_RIGHT: rect_right = longint'($signed(v));
            REG_BOTTOM: rect_bottom = longint'($signed(v));
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        wait (segments_pending.size() == 0 && !start);
        @(posedge clk);
        wait (clips_expected.size() == 0);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(logic [CW-1:0] lo, logic [CW-1:0] hi);
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return CW'($urandom);
        if (m == 1) return lo + CW'($urandom_range(0, 3)) - CW'(2);
        if (m == 2) return hi + CW'($urandom_range(0, 3)) - CW'(2);
        return lo + CW'($urandom_range(0, 32'(hi - lo)));
    endfunction

    task automatic add_segment(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                               logic [CW-1:0] d);
        in_t s;
        s.start_x = a; s.start_y = b; s.end_x = c; s.end_y = d;
        segments_pending.push_back(s);
    endtask

    initial
    begin
        logic [CW-1:0] lo_x, hi_x, lo_y, hi_y;
        rect_left = 0; rect_top = 0; rect_right = 32767; rect_bottom = 32767;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset rectangle, extremes, parallel and degenerate segments
        add_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        add_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        add_segment(16'd100, 16'd100, 16'd100, 16'd100);
        add_segment(-16'sd5, 16'd100, -16'sd5, 16'd100);
        add_segment(16'd0, 16'd0, 16'd0, 16'd0);
        add_segment(16'd50, 16'd0, 16'd900, 16'd0);
        add_segment(-16'sd50, 16'd10, -16'sd900, 16'd10);
        add_segment(16'd10, -16'sd50, 16'd10, 16'd3000);
        add_segment(16'hffff, 16'h0001, 16'h0001, 16'hffff);
        drain_pipeline();

        set_rect(REG_LEFT, -16'sd800); set_rect(REG_TOP, -16'sd640);
        set_rect(REG_RIGHT, 16'd800); set_rect(REG_BOTTOM, 16'd640);
        set_rect(3'd5, 16'd1); // ignored index
        add_segment(-16'sd2000, 16'd0, 16'd2000, 16'd0);
        add_segment(16'd0, -16'sd2000, 16'd0, 16'd2000);
        add_segment(-16'sd2000, -16'sd2000, 16'd2000, 16'd2000);
        add_segment(16'd2000, 16'd0, 16'd3000, 16'd5);
        add_segment(16'd900, 16'd900, -16'sd900, -16'sd900);
        add_segment(16'd800, 16'd640, 16'd800, 16'd640);
        add_segment(16'd801, 16'd0, 16'd801, 16'd0);
        add_segment(-16'sd2000, 16'd700, 16'd2000, 16'd700);
        add_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        drain_pipeline();

        // Inverted rectangle
        set_rect(REG_LEFT, 16'd500); set_rect(REG_RIGHT, -16'sd500);
        add_segment(-16'sd900, 16'd0, 16'd900, 16'd0);
        add_segment(16'd0, 16'd0, 16'd0, 16'd0);
        drain_pipeline();

        // Random phases over varied rectangles, extremes included
        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: begin lo_x = 16'h8000; hi_x = 16'h7fff; lo_y = 16'h8000; hi_y = 16'h7fff; end
                1: begin lo_x = 16'h7fff; hi_x = 16'h7fff; lo_y = 16'h8000; hi_y = 16'h8000; end
                2: begin lo_x = 16'h8000; hi_x = 16'h8000; lo_y = 16'h7fff; hi_y = 16'h7fff; end
                default: begin
                    lo_x = CW'($urandom); lo_y = CW'($urandom);
                    hi_x = lo_x + CW'($urandom_range(0, 8000));
                    hi_y = lo_y + CW'($urandom_range(0, 8000));
                    if ($signed(hi_x) < $signed(lo_x)) hi_x = 16'h7fff;
                    if ($signed(hi_y) < $signed(lo_y)) hi_y = 16'h7fff;
                end
            endcase
            set_rect(REG_LEFT, lo_x); set_rect(REG_TOP, lo_y);
            set_rect(REG_RIGHT, hi_x); set_rect(REG_BOTTOM, hi_y);
            if (ph >= 11) quiet_run = 1'b1;
            for (int n = 0; n < 150; n++) begin
                logic [CW-1:0] sx, sy;
                sx = rand_coord(lo_x - 16'd600, hi_x + 16'd600);
                sy = rand_coord(lo_y - 16'd600, hi_y + 16'd600);
                case ($urandom_range(0, 5))
                    0: add_segment(sx, sy, sx, sy);
                    1: add_segment(sx, sy, rand_coord(lo_x - 16'd600, hi_x + 16'd600), sy);
                    2: add_segment(sx, sy, sx, rand_coord(lo_y - 16'd600, hi_y + 16'd600));
                    default: add_segment(sx, sy, rand_coord(lo_x - 16'd600, hi_x + 16'd600),
                                         rand_coord(lo_y - 16'd600, hi_y + 16'd600));
                endcase
            end
            drain_pipeline();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
